### src/accel_tilt_attitude_filter_macros.svh
// Assertion macros shared by the filter RTL.
`ifndef ACCEL_TILT_ATTITUDE_FILTER_MACROS_SVH
`define ACCEL_TILT_ATTITUDE_FILTER_MACROS_SVH
`ifndef ASSERT_OFF
// Property checked on every clock edge outside reset.
`define ATAF_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("ataf: check failed");
// Condition in one cycle implies a condition in the next.
`define ATAF_ASSERT_NEXT(label, pre, post) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("ataf: sequence check failed");
`else
`define ATAF_ASSERT(label, prop)
`define ATAF_ASSERT_NEXT(label, pre, post)
`endif
`endif

### src/ataf_pkg.sv
package ataf_pkg;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_SQ,
		ST_SQRT,
		ST_CINIT,
		ST_CITER,
		ST_CDONE,
		ST_FILT,
		ST_DONE
	} state_t;

	// event codes carried in tuser
	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_FAIL   = 2'd1,
		OP_RECONF = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	// configuration register indexes
	typedef enum logic [0:0] {
		CFG_ALPHA = 1'b0,
		CFG_LIMIT = 1'b1
	} cfg_idx_t;

	localparam int CORDIC_STAGES_DEF   = 16;
	localparam int ANGLE_FRAC_BITS_DEF = 8;

	localparam logic [15:0] ALPHA_RESET = 16'd4915;
	localparam logic [15:0] ALPHA_MAX   = 16'd32768;
	localparam logic [7:0]  LIMIT_RESET = 8'd3;
	localparam logic [7:0]  CNT_SAT     = 8'hFF;

	// raw to mg: *125 / 2^11, raw to mrad/s: *139703 / 2^20
	localparam logic signed [18:0] ACC_SCALE  = 19'sd125;
	localparam logic signed [18:0] RATE_SCALE = 19'sd139703;
	localparam int ACC_SHIFT   = 11;
	localparam int RATE_SHIFT  = 20;
	localparam int ALPHA_SHIFT = 15;

	// angles in mrad Q16
	localparam logic signed [29:0] PI_Q16      = 30'sd205887416;
	localparam logic signed [29:0] HALF_PI_Q16 = 30'sd102943708;

	// round(atan(2^-i) * 1000 * 2^16)
	function automatic logic signed [29:0] atan_q16(input logic [4:0] i);
		logic signed [29:0] r;
		begin
			case (i)
				5'd0:    r = 30'sd51471854;
				5'd1:    r = 30'sd30385610;
				5'd2:    r = 30'sd16054922;
				5'd3:    r = 30'sd8149729;
				5'd4:    r = 30'sd4090679;
				5'd5:    r = 30'sd2047334;
				5'd6:    r = 30'sd1023917;
				5'd7:    r = 30'sd511990;
				5'd8:    r = 30'sd255999;
				5'd9:    r = 30'sd128000;
				5'd10:   r = 30'sd64000;
				5'd11:   r = 30'sd32000;
				5'd12:   r = 30'sd16000;
				5'd13:   r = 30'sd8000;
				5'd14:   r = 30'sd4000;
				5'd15:   r = 30'sd2000;
				5'd16:   r = 30'sd1000;
				5'd17:   r = 30'sd500;
				5'd18:   r = 30'sd250;
				5'd19:   r = 30'sd125;
				5'd20:   r = 30'sd62;
				5'd21:   r = 30'sd31;
				5'd22:   r = 30'sd16;
				5'd23:   r = 30'sd8;
				default: r = 30'sd0;
			endcase
			atan_q16 = r;
		end
	endfunction

endpackage

### src/accel_tilt_attitude_filter.sv
// Tilt attitude filter. Each input transfer is an event: a sample (six raw
// readings), a read failure, a reconfigure-done notice or a no-op; each event
// gives exactly one result transfer with scaled readings, smoothed roll and
// pitch in mrad and the link status. A sample runs through one shared 32x19
// multiplier (six scalings, two squares, two filter products), a bit-serial
// square root of 24 steps and two passes through one CORDIC vectoring stage.
// The first sample after reset or reconfiguration skips the filter products
// and seeds the estimates. The input is not ready while an event is in work;
// a finished result sits in an output register until taken.
`include "accel_tilt_attitude_filter_macros.svh"

module accel_tilt_attitude_filter #(
	parameter int CORDIC_STAGES   = ataf_pkg::CORDIC_STAGES_DEF,
	parameter int ANGLE_FRAC_BITS = ataf_pkg::ANGLE_FRAC_BITS_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	// input events
	input  logic         s_tvalid,
	output logic         s_tready,
	// raw_accel_x, raw_accel_y, raw_accel_z, raw_gyro_x, raw_gyro_y, raw_gyro_z
	input  logic [95:0]  s_tdata,
	// op
	input  logic [1:0]   s_tuser,
	// results
	output logic         m_tvalid,
	input  logic         m_tready,
	// accel_x_mg, accel_y_mg, accel_z_mg, rate_x_mrad_s, rate_y_mrad_s,
	// rate_z_mrad_s, roll_mrad, pitch_mrad, needs_reconfigure, failure_count
	output logic [111:0] m_tdata,
	// sample_valid
	output logic [0:0]   m_tuser,
	// configuration writes
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	localparam int EST_W      = 13 + ANGLE_FRAC_BITS;
	localparam int DLT_W      = EST_W + 1;
	localparam int ROUND_SH   = 16 - ANGLE_FRAC_BITS;
	localparam longint Z_HALF = (64'sd1 << ROUND_SH) >> 1;
	localparam longint PQ     = (64'sd205887416 + Z_HALF) >> ROUND_SH;
	localparam logic signed [DLT_W-1:0] PQ_D  = DLT_W'(PQ);
	localparam logic signed [DLT_W-1:0] PQ2_D = DLT_W'(2 * PQ);
	localparam logic signed [EST_W-1:0] PQ_E  = EST_W'(PQ);
	localparam int SQRT_STEPS = 24;
	localparam int SQRT_TOP   = 46;
	// the counter is sized for the square root steps, which at the default outnumber the CORDIC stages
	localparam int CNT_W      = $clog2(SQRT_STEPS + 1);
	localparam int CW         = 54;

	// round half away from zero, then shift right
	function automatic logic signed [50:0] rnd_shr(input logic signed [50:0] v,
			input int unsigned sh);
		logic [50:0] m;
		logic [50:0] h;
		begin
			m = v[50] ? 51'(-v) : 51'(v);
			h = (51'(1) << sh) >> 1;
			m = (m + h) >> sh;
			rnd_shr = v[50] ? -$signed(m) : $signed(m);
		end
	endfunction

	ataf_pkg::state_t state_q, state_d;

	logic [15:0]              alpha_q;
	logic [7:0]               limit_q;
	logic signed [15:0]       raw_q [6];
	logic [CNT_W-1:0]         cnt_q;
	logic                     pass_q;
	logic signed [50:0]       prod_s1;
	logic signed [31:0]       mul_a;
	logic signed [18:0]       mul_b;
	logic signed [11:0]       acc_q [3];
	logic signed [13:0]       rate_q [3];
	logic [31:0]              sumsq_q;
	logic [47:0]              rem_q;
	logic [47:0]              res_q;
	logic signed [CW-1:0]     cx_q, cy_q;
	logic signed [29:0]       cz_q;
	logic                     zero_q;
	logic signed [EST_W-1:0]  ang_roll_q, ang_pitch_q;
	logic signed [EST_W-1:0]  roll_est_q, pitch_est_q;
	logic                     seeded_q, link_q, valid_q;
	logic [7:0]               err_cnt_q;
	logic                     m_tvalid_q;
	logic [111:0]             m_tdata_q;
	logic [0:0]               m_tuser_q;

	logic                     in_xfer;
	ataf_pkg::op_t            op;
	logic [15:0]              alpha_c;
	logic signed [DLT_W-1:0]  d_roll_raw, d_roll, d_pitch;
	logic signed [DLT_W-1:0]  step;
	logic signed [DLT_W-1:0]  roll_sum;
	logic [2:0]               wb_idx;
	logic [5:0]               sq_sh;
	logic [47:0]              sq_bit, sq_trial;
	logic signed [CW-1:0]     x0, y0, xs0, ys0, cxs, cys;
	logic signed [29:0]       zc;
	logic signed [50:0]       zr;
	logic [7:0]               fail_cnt;
	logic [12:0]              roll_out;
	logic [11:0]              pitch_out;

	assign cfg_ready = 1'b1;
	assign in_xfer   = s_tvalid && s_tready;
	assign op        = ataf_pkg::op_t'(s_tuser);
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;
	assign m_tuser   = m_tuser_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ataf_pkg::ALPHA_RESET;
			limit_q <= ataf_pkg::LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (ataf_pkg::cfg_idx_t'(cfg_index))
				ataf_pkg::CFG_ALPHA: alpha_q <= cfg_data;
				ataf_pkg::CFG_LIMIT: limit_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// filter deltas, roll takes the short way round
	always_comb begin
		alpha_c    = (alpha_q > ataf_pkg::ALPHA_MAX) ? ataf_pkg::ALPHA_MAX : alpha_q;
		d_roll_raw = DLT_W'(ang_roll_q) - DLT_W'(roll_est_q);
		if (d_roll_raw > PQ_D) begin
			d_roll = d_roll_raw - PQ2_D;
		end else if (d_roll_raw < -PQ_D) begin
			d_roll = d_roll_raw + PQ2_D;
		end else begin
			d_roll = d_roll_raw;
		end
		d_pitch  = DLT_W'(ang_pitch_q) - DLT_W'(pitch_est_q);
		step     = DLT_W'(rnd_shr(prod_s1, ataf_pkg::ALPHA_SHIFT));
		roll_sum = DLT_W'(roll_est_q) + step;
	end

	// square root step, one result bit per cycle
	always_comb begin
		sq_sh    = 6'(SQRT_TOP) - 6'({cnt_q, 1'b0});
		sq_bit   = 48'(1) << sq_sh;
		sq_trial = res_q + sq_bit;
	end

	// CORDIC start vector and shifted terms
	always_comb begin
		if (!pass_q) begin
			x0 = CW'(raw_q[2]);
			y0 = CW'(raw_q[1]);
		end else begin
			x0 = CW'($signed({1'b0, res_q[23:0]}));
			y0 = -(CW'(raw_q[0]) <<< 8);
		end
		xs0 = x0 <<< 24;
		ys0 = y0 <<< 24;
		cxs = cx_q >>> cnt_q;
		cys = cy_q >>> cnt_q;
		if (cz_q > ataf_pkg::PI_Q16) begin
			zc = ataf_pkg::PI_Q16;
		end else if (cz_q < -ataf_pkg::PI_Q16) begin
			zc = -ataf_pkg::PI_Q16;
		end else begin
			zc = cz_q;
		end
		zr = rnd_shr(51'(zc), ROUND_SH);
	end

	assign wb_idx   = 3'(cnt_q - CNT_W'(1));
	assign fail_cnt = (err_cnt_q == ataf_pkg::CNT_SAT) ? err_cnt_q : err_cnt_q + 8'd1;

	// next state, handshake and multiplier operand selection
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		mul_a    = '0;
		mul_b    = '0;
		unique case (state_q)
			ataf_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					if (op == ataf_pkg::OP_SAMPLE && !link_q) begin
						state_d = ataf_pkg::ST_CONV;
					end else begin
						state_d = ataf_pkg::ST_DONE;
					end
				end
			end
			ataf_pkg::ST_CONV: begin
				if (cnt_q < CNT_W'(6)) begin
					mul_a = 32'(raw_q[cnt_q[2:0]]);
					mul_b = (cnt_q < CNT_W'(3)) ? ataf_pkg::ACC_SCALE : ataf_pkg::RATE_SCALE;
				end else begin
					state_d = ataf_pkg::ST_SQ;
				end
			end
			ataf_pkg::ST_SQ: begin
				if (cnt_q == CNT_W'(0)) begin
					mul_a = 32'(raw_q[1]);
					mul_b = 19'(raw_q[1]);
				end else if (cnt_q == CNT_W'(1)) begin
					mul_a = 32'(raw_q[2]);
					mul_b = 19'(raw_q[2]);
				end else begin
					state_d = ataf_pkg::ST_SQRT;
				end
			end
			ataf_pkg::ST_SQRT: begin
				if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
					state_d = ataf_pkg::ST_CINIT;
				end
			end
			ataf_pkg::ST_CINIT: state_d = ataf_pkg::ST_CITER;
			ataf_pkg::ST_CITER: begin
				if (cnt_q == CNT_W'(CORDIC_STAGES - 1)) begin
					state_d = ataf_pkg::ST_CDONE;
				end
			end
			ataf_pkg::ST_CDONE: begin
				state_d = pass_q ? ataf_pkg::ST_FILT : ataf_pkg::ST_CINIT;
			end
			ataf_pkg::ST_FILT: begin
				mul_b = 19'($signed({1'b0, alpha_c}));
				if (cnt_q == CNT_W'(0)) begin
					mul_a = 32'(d_roll);
				end else begin
					mul_a = 32'(d_pitch);
				end
				if (!seeded_q || cnt_q == CNT_W'(2)) begin
					state_d = ataf_pkg::ST_DONE;
				end
			end
			ataf_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					state_d = ataf_pkg::ST_IDLE;
				end
			end
			default: state_d = ataf_pkg::ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ataf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// shared multiplier, registered
	always_ff @(posedge clk) begin
		prod_s1 <= 51'(mul_a * mul_b);
	end

	// step counter and CORDIC pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			pass_q <= 1'b0;
		end else begin
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (state_q == ataf_pkg::ST_IDLE) begin
				pass_q <= 1'b0;
			end else if (state_q == ataf_pkg::ST_CDONE) begin
				pass_q <= 1'b1;
			end
		end
	end

	// scaled readings, held until the next converted sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				acc_q[k]  <= '0;
				rate_q[k] <= '0;
			end
		end else if (state_q == ataf_pkg::ST_CONV && cnt_q != CNT_W'(0)) begin
			case (wb_idx)
				3'd0, 3'd1, 3'd2:
					acc_q[wb_idx[1:0]] <= 12'(rnd_shr(prod_s1, ataf_pkg::ACC_SHIFT));
				default:
					rate_q[2'(wb_idx - 3'd3)] <= 14'(rnd_shr(prod_s1, ataf_pkg::RATE_SHIFT));
			endcase
		end
	end

	// datapath: readings, square root, CORDIC, angles
	always_ff @(posedge clk) begin
		if (state_q == ataf_pkg::ST_IDLE && in_xfer) begin
			for (int k = 0; k < 6; k++) begin
				raw_q[k] <= s_tdata[16*k +: 16];
			end
		end
		if (state_q == ataf_pkg::ST_SQ) begin
			if (cnt_q == CNT_W'(1)) begin
				sumsq_q <= prod_s1[31:0];
			end else if (cnt_q == CNT_W'(2)) begin
				rem_q <= {sumsq_q + prod_s1[31:0], 16'b0};
				res_q <= '0;
			end
		end
		if (state_q == ataf_pkg::ST_SQRT) begin
			if (rem_q >= sq_trial) begin
				rem_q <= rem_q - sq_trial;
				res_q <= (res_q >> 1) + sq_bit;
			end else begin
				res_q <= res_q >> 1;
			end
		end
		if (state_q == ataf_pkg::ST_CINIT) begin
			zero_q <= (x0 == '0) && (y0 == '0);
			if (xs0 < 0) begin
				if (ys0 >= 0) begin
					cx_q <= ys0;
					cy_q <= -xs0;
					cz_q <= ataf_pkg::HALF_PI_Q16;
				end else begin
					cx_q <= -ys0;
					cy_q <= xs0;
					cz_q <= -ataf_pkg::HALF_PI_Q16;
				end
			end else begin
				cx_q <= xs0;
				cy_q <= ys0;
				cz_q <= '0;
			end
		end
		if (state_q == ataf_pkg::ST_CITER) begin
			if (cy_q >= 0) begin
				cx_q <= cx_q + cys;
				cy_q <= cy_q - cxs;
				cz_q <= cz_q + ataf_pkg::atan_q16(5'(cnt_q));
			end else begin
				cx_q <= cx_q - cys;
				cy_q <= cy_q + cxs;
				cz_q <= cz_q - ataf_pkg::atan_q16(5'(cnt_q));
			end
		end
		if (state_q == ataf_pkg::ST_CDONE) begin
			if (!pass_q) begin
				ang_roll_q <= zero_q ? '0 : EST_W'(zr);
			end else begin
				ang_pitch_q <= zero_q ? '0 : EST_W'(zr);
			end
		end
	end

	// estimates and link status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			roll_est_q  <= '0;
			pitch_est_q <= '0;
			seeded_q    <= 1'b0;
			link_q      <= 1'b0;
			valid_q     <= 1'b0;
			err_cnt_q   <= '0;
		end else begin
			if (state_q == ataf_pkg::ST_IDLE && in_xfer) begin
				case (op)
					ataf_pkg::OP_SAMPLE: begin
						if (link_q) begin
							valid_q <= 1'b0;
						end
					end
					ataf_pkg::OP_FAIL: begin
						valid_q   <= 1'b0;
						err_cnt_q <= fail_cnt;
						if (fail_cnt >= limit_q) begin
							link_q <= 1'b1;
						end
					end
					ataf_pkg::OP_RECONF: begin
						err_cnt_q <= '0;
						valid_q   <= 1'b0;
						link_q    <= 1'b0;
						seeded_q  <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == ataf_pkg::ST_FILT) begin
				if (!seeded_q) begin
					roll_est_q  <= ang_roll_q;
					pitch_est_q <= ang_pitch_q;
				end else if (cnt_q == CNT_W'(1)) begin
					if (roll_sum > PQ_D) begin
						roll_est_q <= EST_W'(roll_sum - PQ2_D);
					end else if (roll_sum < -PQ_D) begin
						roll_est_q <= EST_W'(roll_sum + PQ2_D);
					end else begin
						roll_est_q <= EST_W'(roll_sum);
					end
				end else if (cnt_q == CNT_W'(2)) begin
					pitch_est_q <= EST_W'(DLT_W'(pitch_est_q) + step);
				end
				if (!seeded_q || cnt_q == CNT_W'(2)) begin
					seeded_q  <= 1'b1;
					valid_q   <= 1'b1;
					err_cnt_q <= '0;
				end
			end
		end
	end

	// estimates rounded to whole mrad for the result
	assign roll_out  = 13'(rnd_shr(51'(roll_est_q), ANGLE_FRAC_BITS));
	assign pitch_out = 12'(rnd_shr(51'(pitch_est_q), ANGLE_FRAC_BITS));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (state_q == ataf_pkg::ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ataf_pkg::ST_DONE && (!m_tvalid_q || m_tready)) begin
			m_tdata_q <= {err_cnt_q, link_q, pitch_out, roll_out,
				rate_q[2], rate_q[1], rate_q[0], acc_q[2], acc_q[1], acc_q[0]};
			m_tuser_q <= valid_q;
		end
	end

	`ATAF_ASSERT(a_valid_clears_count, valid_q |-> (err_cnt_q == 8'd0))
	`ATAF_ASSERT(a_link_needs_failures, link_q |-> (err_cnt_q != 8'd0))
	`ATAF_ASSERT(a_roll_in_range, (roll_est_q <= PQ_E) && (roll_est_q >= -PQ_E))
	`ATAF_ASSERT(a_cordic_bound, (state_q == ataf_pkg::ST_CITER) |-> (cnt_q < CNT_W'(CORDIC_STAGES)))
	`ATAF_ASSERT_NEXT(a_sample_starts, in_xfer && (op == ataf_pkg::OP_SAMPLE) && !link_q, state_q == ataf_pkg::ST_CONV)

endmodule

### tb/tb_accel_tilt_attitude_filter.sv
`timescale 1ns / 1ps

module tb_accel_tilt_attitude_filter;

	localparam longint ANG_PI_Q16   = 205887416;
	localparam longint ANG_HALF_PI  = 102943708;
	localparam int     FRAC         = 8;
	localparam int     STAGES       = 16;
	localparam int     STALL_LIMIT  = 6000;
	localparam int     DRAIN_CYCLES = 100;
	localparam int     HOLD_CYCLES  = 300;

	// one result, fields at their port widths
	typedef struct {
		logic signed [11:0] acc_x, acc_y, acc_z;
		logic signed [13:0] rate_x, rate_y, rate_z;
		logic signed [12:0] roll;
		logic signed [11:0] pitch;
		logic               good;
		logic               lost;
		logic [7:0]         fails;
	} tilt_res_t;

	// one stimulus row
	typedef struct {
		ataf_pkg::op_t op;
		logic [95:0]   raw;
		bit            pinned;
		tilt_res_t     want;
	} event_row_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	logic [95:0]  s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid;
	logic         m_tready;
	logic [111:0] m_tdata;
	logic [0:0]   m_tuser;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [0:0]   cfg_index;
	logic [15:0]  cfg_data;

	// pinned expectation travels alongside the input transfer
	logic         pin_en;
	tilt_res_t    pin_res;

	// shadow of the block's state
	longint roll_est, pitch_est;
	bit     seeded, link_down, good_flag;
	int     fail_cnt;
	longint held[6];
	int     alpha_reg, limit_reg;

	tilt_res_t  expected_q[$];
	event_row_t rows[$];
	int         errors;
	int         send_idle, recv_idle;
	logic       hold_go;
	int         hold_left;
	int         quiet_cycles;

	accel_tilt_attitude_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint round_away(longint v, int s);
		longint m;
		longint r;
		if (s == 0) return v;
		m = (v < 0) ? -v : v;
		r = (m + (64'sd1 <<< (s - 1))) >>> s;
		return (v < 0) ? -r : r;
	endfunction

	function automatic longint int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(res);
	endfunction

	function automatic longint atan_step(int i);
		longint t[16] = '{51471854, 30385610, 16054922, 8149729, 4090679, 2047334,
			1023917, 511990, 255999, 128000, 64000, 32000, 16000, 8000, 4000, 2000};
		return t[i];
	endfunction

	// vectoring CORDIC, angle in mrad with FRAC fraction bits
	function automatic longint vector_angle(longint y, longint x);
		longint z, t, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		x = x <<< 24;
		y = y <<< 24;
		if (x < 0) begin
			if (y >= 0) begin
				t = x; x = y; y = -t; z = ANG_HALF_PI;
			end else begin
				t = x; x = -y; y = t; z = -ANG_HALF_PI;
			end
		end
		for (int i = 0; i < STAGES; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x += ys; y -= xs; z += atan_step(i);
			end else begin
				x -= ys; y += xs; z -= atan_step(i);
			end
		end
		if (z > ANG_PI_Q16) z = ANG_PI_Q16;
		if (z < -ANG_PI_Q16) z = -ANG_PI_Q16;
		return round_away(z, 16 - FRAC);
	endfunction

	function automatic longint smooth_delta(longint d);
		longint a;
		a = (alpha_reg > 32768) ? 32768 : alpha_reg;
		return round_away(a * d, 15);
	endfunction

	function automatic longint raw_field(logic [95:0] raw, int k);
		return longint'($signed(raw[16*k +: 16]));
	endfunction

	// advance the shadow state by one event and return its result
	function automatic tilt_res_t tilt_predict(ataf_pkg::op_t op, logic [95:0] raw);
		tilt_res_t r;
		longint ax, ay, az, roll, pitch, mag, d, pq;
		pq = round_away(ANG_PI_Q16, 16 - FRAC);
		case (op)
			ataf_pkg::OP_SAMPLE: begin
				if (link_down) begin
					good_flag = 0;
				end else begin
					ax = raw_field(raw, 0);
					ay = raw_field(raw, 1);
					az = raw_field(raw, 2);
					for (int k = 0; k < 3; k++)
						held[k] = round_away(raw_field(raw, k) * 125, 11);
					for (int k = 3; k < 6; k++)
						held[k] = round_away(raw_field(raw, k) * 139703, 20);
					roll = vector_angle(ay, az);
					mag = int_sqrt(longint'(ay * ay + az * az) <<< 16);
					pitch = vector_angle(-ax * 256, mag);
					if (!seeded) begin
						roll_est = roll;
						pitch_est = pitch;
						seeded = 1;
					end else begin
						// roll goes the short way round and wraps
						d = roll - roll_est;
						if (d > pq) d -= 2 * pq;
						else if (d < -pq) d += 2 * pq;
						roll_est += smooth_delta(d);
						if (roll_est > pq) roll_est -= 2 * pq;
						else if (roll_est < -pq) roll_est += 2 * pq;
						pitch_est += smooth_delta(pitch - pitch_est);
					end
					good_flag = 1;
					fail_cnt = 0;
				end
			end
			ataf_pkg::OP_FAIL: begin
				good_flag = 0;
				if (fail_cnt < 255) fail_cnt++;
				if (fail_cnt >= limit_reg) link_down = 1;
			end
			ataf_pkg::OP_RECONF: begin
				fail_cnt = 0;
				good_flag = 0;
				link_down = 0;
				seeded = 0;
			end
			default: ;
		endcase
		r.acc_x = held[0][11:0];
		r.acc_y = held[1][11:0];
		r.acc_z = held[2][11:0];
		r.rate_x = held[3][13:0];
		r.rate_y = held[4][13:0];
		r.rate_z = held[5][13:0];
		r.roll = 13'(round_away(roll_est, FRAC));
		r.pitch = 12'(round_away(pitch_est, FRAC));
		r.good = good_flag;
		r.lost = link_down;
		r.fails = fail_cnt[7:0];
		return r;
	endfunction

	function automatic void check_field(string name, longint want, longint got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endfunction

	// predictor on input transfers, config shadow on register writes
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready) begin
			tilt_res_t p;
			p = tilt_predict(ataf_pkg::op_t'(s_tuser), s_tdata);
			if (pin_en) expected_q.push_back(pin_res);
			else expected_q.push_back(p);
		end
		if (arst_n && cfg_valid && cfg_ready) begin
			if (cfg_index == ataf_pkg::CFG_ALPHA) alpha_reg = cfg_data;
			else limit_reg = cfg_data[7:0];
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			tilt_res_t w;
			if (expected_q.size() == 0) begin
				$error("result transfer with nothing expected");
				errors++;
			end else begin
				w = expected_q.pop_front();
				check_field("accel_x_mg", w.acc_x, $signed(m_tdata[11:0]));
				check_field("accel_y_mg", w.acc_y, $signed(m_tdata[23:12]));
				check_field("accel_z_mg", w.acc_z, $signed(m_tdata[35:24]));
				check_field("rate_x_mrad_s", w.rate_x, $signed(m_tdata[49:36]));
				check_field("rate_y_mrad_s", w.rate_y, $signed(m_tdata[63:50]));
				check_field("rate_z_mrad_s", w.rate_z, $signed(m_tdata[77:64]));
				check_field("roll_mrad", w.roll, $signed(m_tdata[90:78]));
				check_field("pitch_mrad", w.pitch, $signed(m_tdata[102:91]));
				check_field("needs_reconfigure", w.lost, m_tdata[103]);
				check_field("failure_count", w.fails, m_tdata[111:104]);
				check_field("sample_valid", w.good, m_tuser[0]);
			end
		end
	end

	// receiver: random stalls plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			hold_left <= 0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_go) begin
			m_tready <= 1'b0;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("FAIL accel_tilt_attitude_filter");
			$finish;
		end
	end

	task automatic send_event(ataf_pkg::op_t op, logic [95:0] raw, bit pinned,
			tilt_res_t want);
		if ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			pin_en <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= raw;
		pin_en <= pinned;
		pin_res <= want;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic write_reg(ataf_pkg::cfg_idx_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// lower valid, let the block drain, then leave it idle
	task automatic settle();
		s_tvalid <= 1'b0;
		pin_en <= 1'b0;
		@(posedge clk);
		while (expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [95:0] pack_raw(int a0, int a1, int a2, int g0, int g1, int g2);
		return {16'(g2), 16'(g1), 16'(g0), 16'(a2), 16'(a1), 16'(a0)};
	endfunction

	function automatic int pick_extreme();
		int v[6] = '{-32768, -32767, -1, 0, 1, 32767};
		return v[$urandom_range(5)];
	endfunction

	// sample readings: mostly random accelerations within half scale, some wide-open
	function automatic logic [95:0] random_sample();
		logic [95:0] d;
		case ($urandom_range(5))
			0: d = {$urandom, $urandom, $urandom};
			1: d = pack_raw(pick_extreme(), pick_extreme(), pick_extreme(),
				pick_extreme(), pick_extreme(), pick_extreme());
			// upside down with small ay: roll near +-pi, exercises the wrap
			2: d = pack_raw($urandom_range(0, 4000) - 2000, $urandom_range(0, 600) - 300,
				-$urandom_range(12000, 20000), $urandom_range(0, 2000) - 1000,
				$urandom_range(0, 2000) - 1000, $urandom_range(0, 2000) - 1000);
			default: d = pack_raw($urandom_range(0, 32767) - 16384,
				$urandom_range(0, 32767) - 16384, $urandom_range(0, 32767) - 16384,
				$urandom_range(0, 65535) - 32768, $urandom_range(0, 8191) - 4096,
				$urandom_range(0, 8191) - 4096);
		endcase
		return d;
	endfunction

	task automatic random_events(int count);
		tilt_res_t none;
		int r;
		none = '{default: '0};
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 70) send_event(ataf_pkg::OP_SAMPLE, random_sample(), 0, none);
			else if (r < 85)
				send_event(ataf_pkg::OP_FAIL, {$urandom, $urandom, $urandom}, 0, none);
			else if (r < 94)
				send_event(ataf_pkg::OP_RECONF, {$urandom, $urandom, $urandom}, 0, none);
			else send_event(ataf_pkg::OP_NOP, {$urandom, $urandom, $urandom}, 0, none);
		end
	endtask

	task automatic add_row(ataf_pkg::op_t op, logic [95:0] raw, bit pinned, tilt_res_t want);
		event_row_t e;
		e.op = op;
		e.raw = raw;
		e.pinned = pinned;
		e.want = want;
		rows.push_back(e);
	endtask

	initial begin
		tilt_res_t none, w;
		none = '{default: '0};
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ataf_pkg::OP_SAMPLE;
		cfg_valid = 1'b0;
		cfg_index = ataf_pkg::CFG_ALPHA;
		cfg_data = '0;
		pin_en = 1'b0;
		pin_res = none;
		hold_go = 1'b0;
		quiet_cycles = 0;
		errors = 0;
		send_idle = 32;
		recv_idle = 82;
		alpha_reg = 4915;
		limit_reg = 3;
		roll_est = 0;
		pitch_est = 0;
		seeded = 0;
		link_down = 0;
		good_flag = 0;
		fail_cnt = 0;
		for (int k = 0; k < 6; k++) held[k] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: failure counting up to the default limit from reset
		w = none; w.fails = 1;
		add_row(ataf_pkg::OP_FAIL, '0, 1, w);
		w.fails = 2;
		add_row(ataf_pkg::OP_FAIL, '1, 1, w);
		w.fails = 3; w.lost = 1;
		add_row(ataf_pkg::OP_FAIL, '0, 1, w);
		// sample while the link is down: nothing converted
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(1000, 2000, 3000, 400, 500, 600), 1, w);
		add_row(ataf_pkg::OP_NOP, '1, 1, w);
		add_row(ataf_pkg::OP_RECONF, '0, 1, none);
		// zero vector seeds a zero attitude
		w = none; w.good = 1;
		add_row(ataf_pkg::OP_SAMPLE, '0, 1, w);
		// full-scale readings drive the conversions to their extremes
		w.acc_x = 2000; w.acc_y = 2000; w.acc_z = 2000;
		w.rate_x = 4366; w.rate_y = 4366; w.rate_z = 4366;
		add_row(ataf_pkg::OP_RECONF, '0, 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(32767, 32767, 32767, 32767, 32767, 32767),
			0, none);
		add_row(ataf_pkg::OP_SAMPLE,
			pack_raw(-32768, -32768, -32768, -32768, -32768, -32768), 0, none);
		// roll across the +-pi seam, both ways
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(0, 200, -16384, 0, 0, 0), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(0, -200, -16384, 0, 0, 0), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(0, 300, -16384, 0, 0, 0), 0, none);
		// negative x with negative y, straight down, pitch extremes
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(0, -16384, -100, 0, 0, 0), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(0, 0, -16384, 0, 0, 0), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(16384, 0, 0, 0, 0, 0), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(-16384, 0, 0, -1, 1, -1), 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(100, 16384, 0, 0, 0, 0), 0, none);
		// a failure holds readings, a sample clears the counter
		add_row(ataf_pkg::OP_FAIL, '0, 0, none);
		add_row(ataf_pkg::OP_SAMPLE, pack_raw(-500, 700, 16000, 12, -34, 56), 0, none);
		add_row(ataf_pkg::OP_NOP, '0, 0, none);
		foreach (rows[i]) send_event(rows[i].op, rows[i].raw, rows[i].pinned, rows[i].want);
		settle();

		// random phases over several register settings
		write_reg(ataf_pkg::CFG_ALPHA, 16'd0);
		write_reg(ataf_pkg::CFG_LIMIT, 16'd1);
		random_events(110);
		settle();
		write_reg(ataf_pkg::CFG_ALPHA, ataf_pkg::ALPHA_MAX);
		write_reg(ataf_pkg::CFG_LIMIT, 16'd255);
		random_events(110);
		settle();
		send_idle = 82;
		recv_idle = 32;
		write_reg(ataf_pkg::CFG_ALPHA, 16'hFFFF);
		write_reg(ataf_pkg::CFG_LIMIT, 16'd0);
		random_events(110);
		settle();
		write_reg(ataf_pkg::CFG_ALPHA, 16'd1);
		write_reg(ataf_pkg::CFG_LIMIT, 16'hFF02);
		random_events(110);
		settle();
		send_idle = 0;
		recv_idle = 0;
		write_reg(ataf_pkg::CFG_ALPHA, 16'd16384);
		write_reg(ataf_pkg::CFG_LIMIT, 16'd3);
		random_events(40);
		// long receiver hold-off while the sender keeps offering
		hold_go <= 1'b1;
		@(posedge clk);
		hold_go <= 1'b0;
		random_events(70);
		settle();
		// counter saturation with the highest limit
		write_reg(ataf_pkg::CFG_ALPHA, 16'd4915);
		write_reg(ataf_pkg::CFG_LIMIT, 16'd255);
		send_event(ataf_pkg::OP_RECONF, '0, 0, none);
		for (int i = 0; i < 258; i++)
			send_event(ataf_pkg::OP_FAIL, {$urandom, $urandom, $urandom}, 0, none);
		random_events(20);
		settle();

		if (expected_q.size() != 0) begin
			$error("%0d results never arrived", expected_q.size());
			errors++;
		end
		if (errors == 0) begin
			$display("PASS accel_tilt_attitude_filter");
		end else begin
			$display("FAIL accel_tilt_attitude_filter");
		end
		$finish;
	end

endmodule
